// ===== src/rdcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcc_pkg
// Shared types, thresholds and helpers of the ROI dominant colour classifier.
// ----------------------------------------------------------------------------
package rdcc_pkg;

	localparam int MAX_COLS_DEF = 2048;
	localparam int MAX_ROWS_DEF = 2048;
	localparam int NUM_BINS     = 9;

	localparam int HUE_W   = 8;
	localparam int CHAN_W  = 8;
	localparam int POS_W   = 11;
	localparam int SIZE_W  = 12;
	localparam int SPAN_W  = 13;
	localparam int COUNT_W = 23;
	localparam int CFG_W   = 13;
	localparam int CFG_IDX_W = 3;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 8;

	localparam logic [CHAN_W-1:0] L_BLACK_MAX = 8'd25;
	localparam logic [CHAN_W-1:0] L_WHITE_MIN = 8'd230;
	localparam logic [CHAN_W-1:0] S_GRAY_MAX  = 8'd25;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [3:0] {
		COLOR_RED     = 4'd0,
		COLOR_YELLOW  = 4'd1,
		COLOR_GREEN   = 4'd2,
		COLOR_CYAN    = 4'd3,
		COLOR_BLUE    = 4'd4,
		COLOR_MAGENTA = 4'd5,
		COLOR_GRAY    = 4'd6,
		COLOR_BLACK   = 4'd7,
		COLOR_WHITE   = 4'd8
	} color_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_REGION_LEFT  = 3'd2,
		REG_REGION_TOP   = 3'd3,
		REG_REGION_COLS  = 3'd4,
		REG_REGION_ROWS  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [3:0] idx;
		count_t     cnt;
	} cand_t;

	// keep the lower index on a tie
	function automatic cand_t pick_max(input cand_t lo, input cand_t hi);
		cand_t r;
		r = (hi.cnt > lo.cnt) ? hi : lo;
		return r;
	endfunction

endpackage

// ===== src/rdcc_classify.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdcc_classify
// Sorts one HLS pixel into its colour bin.
// ----------------------------------------------------------------------------
module rdcc_classify
	import rdcc_pkg::*;
(
	input  logic [HUE_W-1:0]  hue_half,
	input  logic [CHAN_W-1:0] lightness,
	input  logic [CHAN_W-1:0] saturation,
	output color_t            color
);

	logic [HUE_W:0] hue;

	assign hue = {hue_half, 1'b0};

	always_comb begin
		if (lightness <= L_BLACK_MAX) begin
			color = COLOR_BLACK;
		end else if (lightness >= L_WHITE_MIN) begin
			color = COLOR_WHITE;
		end else if (saturation <= S_GRAY_MAX) begin
			color = COLOR_GRAY;
		end else if (hue inside {[9'd21:9'd70]}) begin
			color = COLOR_YELLOW;
		end else if (hue inside {[9'd71:9'd155]}) begin
			color = COLOR_GREEN;
		end else if (hue inside {[9'd156:9'd210]}) begin
			color = COLOR_CYAN;
		end else if (hue inside {[9'd211:9'd270]}) begin
			color = COLOR_BLUE;
		end else if (hue inside {[9'd271:9'd320]}) begin
			color = COLOR_MAGENTA;
		end else begin
			color = COLOR_RED;
		end
	end

endmodule

// ===== src/roi_dominant_color_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_dominant_color_classifier
// Counts colour bins of pixels inside a clipped region and reports the
// dominant bin at each frame end.
//
// Pixels enter on the s_ stream, one transaction per pixel, frame_end on
// s_tlast. Pixels inside the clipped region are sorted into nine colour bins
// with saturating 23-bit counters. The pixel carrying s_tlast closes the
// frame: its count is taken, the counters are copied and cleared, and the
// first bin with the highest count (white if nothing was counted) leaves on
// the m_ stream as one transaction.
// Throughput: one pixel per cycle while s_tready is high. The result of a
// frame end passes the input register, the classified-pixel register, the
// frame snapshot, the group-winner register and the output register.
// A stalled m_ side holds the result; up to three results queue in the tree
// and output stages while pixels keep flowing, and only a fourth pending
// frame end lowers s_tready. Reset clears the counters, the pipeline and
// the configuration registers to their defaults. The cfg_ port takes a
// register write on any cycle with cfg_we high; write only while idle.
// ----------------------------------------------------------------------------
module roi_dominant_color_classifier
	import rdcc_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// hue_half[7:0], lightness[15:8], saturation[23:16], pixel_col[34:24],
	// pixel_row[45:35], zero pad[47:46]
	input  logic [S_DATA_W-1:0]  s_tdata,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// top_colour[3:0], zero pad[7:4]
	output logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [SIZE_W-1:0] image_width_q, image_height_q;
	logic [SIZE_W-1:0] region_left_q, region_top_q;
	logic [SPAN_W-1:0] region_cols_q, region_rows_q;

	logic              valid_s1, last_s1;
	logic [HUE_W-1:0]  hue_s1;
	logic [CHAN_W-1:0] light_s1, sat_s1;
	logic [POS_W-1:0]  col_s1, row_s1;

	logic   valid_s2, last_s2, hit_s2;
	color_t color_s2;

	count_t counts_q [NUM_BINS];
	count_t counts_s3 [NUM_BINS];
	logic   valid_s3;

	cand_t  cand_s4 [3];
	logic   valid_s4;

	logic   out_valid_q;
	color_t dom_q;

	logic   out_free, s4_ready, s3_ready, s2_ready, s1_ready, adv_s2;
	color_t color_c;
	logic   hit_c;
	count_t counts_nx [NUM_BINS];
	cand_t  grp_c [3];
	cand_t  best_c;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= SIZE_W'(2048);
			image_height_q <= SIZE_W'(2048);
			region_left_q  <= '0;
			region_top_q   <= '0;
			region_cols_q  <= SPAN_W'(2048);
			region_rows_q  <= SPAN_W'(2048);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[SIZE_W-1:0];
				REG_REGION_LEFT:  region_left_q  <= cfg_data[SIZE_W-1:0];
				REG_REGION_TOP:   region_top_q   <= cfg_data[SIZE_W-1:0];
				REG_REGION_COLS:  region_cols_q  <= cfg_data;
				REG_REGION_ROWS:  region_rows_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// flow control
	assign out_free = !out_valid_q || m_tready;
	assign s4_ready = !valid_s4 || out_free;
	assign s3_ready = !valid_s3 || s4_ready;
	assign s2_ready = !(valid_s2 && last_s2) || s3_ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign s_tready = s1_ready;
	assign adv_s2   = valid_s2 && s2_ready;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && s_tvalid) begin
			hue_s1   <= s_tdata[7:0];
			light_s1 <= s_tdata[15:8];
			sat_s1   <= s_tdata[23:16];
			col_s1   <= s_tdata[34:24];
			row_s1   <= s_tdata[45:35];
			last_s1  <= s_tlast;
		end
	end

	rdcc_classify u_classify (
		.hue_half   (hue_s1),
		.lightness  (light_s1),
		.saturation (sat_s1),
		.color      (color_c)
	);

	// region test: lo <= pos < min(lo + len, frame, max)
	logic [POS_W-1:0]  x0, y0;
	logic [POS_W+2:0]  x_end, y_end;
	logic              in_x, in_y;

	assign x0    = region_left_q[SIZE_W-1] ? '0 : region_left_q[POS_W-1:0];
	assign y0    = region_top_q[SIZE_W-1] ? '0 : region_top_q[POS_W-1:0];
	assign x_end = {3'b000, x0} + {1'b0, region_cols_q};
	assign y_end = {3'b000, y0} + {1'b0, region_rows_q};
	assign in_x  = (col_s1 >= x0) && ({3'b000, col_s1} < x_end) &&
		({1'b0, col_s1} < image_width_q) && (32'(col_s1) < 32'(MAX_COLS));
	assign in_y  = (row_s1 >= y0) && ({3'b000, row_s1} < y_end) &&
		({1'b0, row_s1} < image_height_q) && (32'(row_s1) < 32'(MAX_ROWS));
	assign hit_c = in_x && in_y;

	// stage 2: classified pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			color_s2 <= color_c;
			hit_s2   <= hit_c;
			last_s2  <= last_s1;
		end
	end

	// counter update, saturating
	always_comb begin
		for (int i = 0; i < NUM_BINS; i++) begin
			counts_nx[i] = counts_q[i];
			if (hit_s2 && (color_s2 == color_t'(i)) && (counts_q[i] != COUNT_MAX)) begin
				counts_nx[i] = counts_q[i] + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (adv_s2) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				counts_q[i] <= last_s2 ? '0 : counts_nx[i];
			end
		end
	end

	// stage 3: frame snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s3_ready) begin
			valid_s3 <= adv_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && adv_s2 && last_s2) begin
			counts_s3 <= counts_nx;
		end
	end

	always_comb begin
		for (int g = 0; g < 3; g++) begin
			grp_c[g] = pick_max(
				pick_max('{idx: 4'(3*g), cnt: counts_s3[3*g]},
					'{idx: 4'(3*g+1), cnt: counts_s3[3*g+1]}),
				'{idx: 4'(3*g+2), cnt: counts_s3[3*g+2]});
		end
	end

	// stage 4: three group winners
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (s4_ready) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s4_ready && valid_s3) begin
			cand_s4 <= grp_c;
		end
	end

	assign best_c = pick_max(pick_max(cand_s4[0], cand_s4[1]), cand_s4[2]);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s4) begin
			dom_q <= (best_c.cnt == '0) ? COLOR_WHITE : color_t'(best_c.idx);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, dom_q};

endmodule

// ===== tb/roi_dominant_color_classifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roi_dominant_color_classifier_tb
// Self-checking bench for the ROI dominant colour classifier.
//
// A queue of pixel transactions feeds a clocked driver. A clocked monitor
// tallies every accepted pixel into a local copy of the nine colour bins,
// using its own copy of the region registers. On each frame end it pushes the
// dominant colour that the frame should give, and it checks every result
// transaction against the oldest pending colour. A directed set of pixels
// covers the band edges, the lightness and saturation limits, and a tie. It is
// followed by random frames over a series of register settings that include
// full-frame, empty, single-pixel, clamped and trimmed regions. Both stream
// sides insert random idle cycles, with stretches that run without any.
// ----------------------------------------------------------------------------
module roi_dominant_color_classifier_tb;
	import rdcc_pkg::*;

	localparam int HUE_YELLOW_LO  = 21;
	localparam int HUE_YELLOW_HI  = 70;
	localparam int HUE_GREEN_HI   = 155;
	localparam int HUE_CYAN_HI    = 210;
	localparam int HUE_BLUE_HI    = 270;
	localparam int HUE_MAGENTA_HI = 320;
	localparam int POS_MAX        = (1 << POS_W) - 1;
	localparam int PIXELS_PER_SETUP = 138;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		logic [HUE_W-1:0]  hue_half;
		logic [CHAN_W-1:0] lightness;
		logic [CHAN_W-1:0] saturation;
		logic [POS_W-1:0]  pixel_col;
		logic [POS_W-1:0]  pixel_row;
		logic              frame_end;
	} pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_DATA_W-1:0]  s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	roi_dominant_color_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// shadow of the region registers and the colour bins
	logic [SIZE_W-1:0] img_w_reg  = 12'd2048;
	logic [SIZE_W-1:0] img_h_reg  = 12'd2048;
	logic [SIZE_W-1:0] left_reg   = '0;
	logic [SIZE_W-1:0] top_reg    = '0;
	logic [SPAN_W-1:0] cols_reg   = 13'd2048;
	logic [SPAN_W-1:0] rows_reg   = 13'd2048;
	count_t            bin_tally [NUM_BINS];

	pixel_t pixel_queue [$];
	color_t color_expect [$];
	pixel_t cur_pixel;

	bit pix_busy = 1'b0;
	bit pix_taken = 1'b0;
	bit s_gaps_on = 1'b1;
	bit m_gaps_on = 1'b1;
	int pix_gap = 0;
	int res_stall = 0;
	int mismatches = 0;
	int pixels_seen = 0;
	int frames_seen = 0;
	int setups_run = 0;

	function automatic color_t classify_pixel(logic [HUE_W-1:0] hh, logic [CHAN_W-1:0] l,
			logic [CHAN_W-1:0] s);
		int hue;
		hue = int'(hh) * 2;
		if (l <= L_BLACK_MAX) return COLOR_BLACK;
		if (l >= L_WHITE_MIN) return COLOR_WHITE;
		if (s <= S_GRAY_MAX) return COLOR_GRAY;
		if (hue >= HUE_YELLOW_LO && hue <= HUE_YELLOW_HI) return COLOR_YELLOW;
		if (hue > HUE_YELLOW_HI && hue <= HUE_GREEN_HI) return COLOR_GREEN;
		if (hue > HUE_GREEN_HI && hue <= HUE_CYAN_HI) return COLOR_CYAN;
		if (hue > HUE_CYAN_HI && hue <= HUE_BLUE_HI) return COLOR_BLUE;
		if (hue > HUE_BLUE_HI && hue <= HUE_MAGENTA_HI) return COLOR_MAGENTA;
		return COLOR_RED;
	endfunction

	// clipped span of one axis: first position and length (empty when n <= 0)
	task automatic span_of(input int start, input int len, input int frame, input int lim_max,
			output int lo, output int n);
		int lim;
		lo = (start < 0) ? 0 : start;
		lim = (frame > lim_max) ? lim_max : frame;
		n = len;
		if (lo + n > lim) n = lim - lo;
	endtask

	task automatic col_span(output int lo, output int n);
		span_of(int'($signed(left_reg)), int'(cols_reg), int'(img_w_reg), MAX_COLS_DEF, lo, n);
	endtask

	task automatic row_span(output int lo, output int n);
		span_of(int'($signed(top_reg)), int'(rows_reg), int'(img_h_reg), MAX_ROWS_DEF, lo, n);
	endtask

	task automatic tally_pixel(input pixel_t p);
		int     cx, cn, ry, rn;
		int     b;
		count_t best;
		color_t dom;
		col_span(cx, cn);
		row_span(ry, rn);
		if (cn > 0 && rn > 0 && int'(p.pixel_col) >= cx && int'(p.pixel_col) < cx + cn &&
				int'(p.pixel_row) >= ry && int'(p.pixel_row) < ry + rn) begin
			b = int'(classify_pixel(p.hue_half, p.lightness, p.saturation));
			if (bin_tally[b] != COUNT_MAX) bin_tally[b] = bin_tally[b] + 1'b1;
		end
		if (p.frame_end) begin
			best = '0;
			dom = COLOR_WHITE;
			for (int i = 0; i < NUM_BINS; i++) begin
				if (bin_tally[i] > best) begin
					best = bin_tally[i];
					dom = color_t'(i);
				end
			end
			for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
			color_expect.push_back(dom);
		end
	endtask

	// pixel driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (pix_taken) begin
				pix_busy = 1'b0;
				pix_taken = 1'b0;
			end
			if (!pix_busy) begin
				if (pix_gap > 0) begin
					pix_gap--;
					s_tvalid <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					cur_pixel = pixel_queue.pop_front();
					s_tdata <= {2'b00, cur_pixel.pixel_row, cur_pixel.pixel_col,
						cur_pixel.saturation, cur_pixel.lightness, cur_pixel.hue_half};
					s_tlast <= cur_pixel.frame_end;
					s_tvalid <= 1'b1;
					pix_busy = 1'b1;
					if ($urandom_range(0, 31) == 0) s_gaps_on = !s_gaps_on;
					pix_gap = s_gaps_on ? $urandom_range(0, 5) : 0;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_stall > 0) begin
				res_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		color_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				tally_pixel(cur_pixel);
				pix_taken = 1'b1;
				pixels_seen++;
			end
			if (m_tvalid && m_tready) begin
				if (color_expect.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected result transaction, m_tdata=0x%02h",
							$realtime, m_tdata);
				end else begin
					want = color_expect.pop_front();
					frames_seen++;
					if (m_tdata !== {4'h0, want}) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: dominant colour mismatch, expected 0x%02h got 0x%02h",
								$realtime, {4'h0, want}, m_tdata);
					end
				end
				if ($urandom_range(0, 31) == 0) m_gaps_on = !m_gaps_on;
				res_stall = m_gaps_on ? $urandom_range(0, 5) : 0;
			end
		end
	end

	task automatic push_pixel(input int hh, input int l, input int s, input int col,
			input int row, input bit last);
		pixel_t p;
		p.hue_half = hh[HUE_W-1:0];
		p.lightness = l[CHAN_W-1:0];
		p.saturation = s[CHAN_W-1:0];
		p.pixel_col = col[POS_W-1:0];
		p.pixel_row = row[POS_W-1:0];
		p.frame_end = last;
		pixel_queue.push_back(p);
	endtask

	task automatic wait_idle;
		while (pixel_queue.size() != 0 || pix_busy || s_tvalid || color_expect.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		case (idx)
			REG_IMAGE_WIDTH: img_w_reg = value[SIZE_W-1:0];
			REG_IMAGE_HEIGHT: img_h_reg = value[SIZE_W-1:0];
			REG_REGION_LEFT: left_reg = value[SIZE_W-1:0];
			REG_REGION_TOP: top_reg = value[SIZE_W-1:0];
			REG_REGION_COLS: cols_reg = value[SPAN_W-1:0];
			REG_REGION_ROWS: rows_reg = value[SPAN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setup(input int w, input int h, input int left, input int top,
			input int cols, input int rows);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_REGION_LEFT, left & 12'hFFF);
		write_reg(REG_REGION_TOP, top & 12'hFFF);
		write_reg(REG_REGION_COLS, cols);
		write_reg(REG_REGION_ROWS, rows);
		@(negedge clk);
		cfg_we <= 1'b0;
		setups_run++;
	endtask

	function automatic int pick_pos(int lo, int n);
		int a, b;
		if ($urandom_range(0, 9) < 4) return $urandom_range(0, POS_MAX);
		a = lo - 2;
		b = lo + ((n > 0) ? n : 1) + 1;
		if (a < 0) a = 0;
		if (a > POS_MAX) a = POS_MAX;
		if (b > POS_MAX) b = POS_MAX;
		return $urandom_range(a, b);
	endfunction

	function automatic pixel_t rand_shade();
		pixel_t p;
		p = '{default: '0};
		p.hue_half = HUE_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 180)
			: $urandom_range(0, 255));
		case ($urandom_range(0, 7))
			0: p.lightness = CHAN_W'($urandom_range(0, 25));
			1: p.lightness = CHAN_W'($urandom_range(230, 255));
			2: p.lightness = ($urandom_range(0, 1) != 0) ? 8'd25 : 8'd230;
			3: p.lightness = ($urandom_range(0, 1) != 0) ? 8'd26 : 8'd229;
			default: p.lightness = CHAN_W'($urandom_range(26, 229));
		endcase
		case ($urandom_range(0, 5))
			0: p.saturation = CHAN_W'($urandom_range(0, 25));
			1: p.saturation = ($urandom_range(0, 1) != 0) ? 8'd25 : 8'd26;
			default: p.saturation = CHAN_W'($urandom_range(26, 255));
		endcase
		return p;
	endfunction

	task automatic queue_frames(input int n_items);
		int     made, flen, r, cx, cn, ry, rn;
		pixel_t fav, p;
		made = 0;
		col_span(cx, cn);
		row_span(ry, rn);
		while (made < n_items) begin
			r = $urandom_range(0, 19);
			if (r < 14) flen = $urandom_range(1, 12);
			else if (r < 19) flen = $urandom_range(13, 60);
			else flen = 1;
			fav = rand_shade();
			for (int i = 0; i < flen; i++) begin
				p = ($urandom_range(0, 1) != 0) ? fav : rand_shade();
				p.pixel_col = POS_W'(pick_pos(cx, cn));
				p.pixel_row = POS_W'(pick_pos(ry, rn));
				p.frame_end = (i == flen - 1);
				pixel_queue.push_back(p);
			end
			made += flen;
		end
	endtask

	initial begin
		int w, h, left, top, cols, rows;
		for (int i = 0; i < NUM_BINS; i++) bin_tally[i] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// single-pixel frames across the thresholds and hue band edges
		push_pixel(0, 0, 0, 0, 0, 1);
		push_pixel(0, 25, 255, POS_MAX, POS_MAX, 1);
		push_pixel(255, 26, 26, 1, 1, 1);
		push_pixel(0, 229, 26, 2, 2, 1);
		push_pixel(0, 230, 0, 3, 3, 1);
		push_pixel(0, 255, 255, 4, 4, 1);
		push_pixel(50, 100, 25, 5, 5, 1);
		push_pixel(50, 100, 26, 6, 6, 1);
		push_pixel(10, 128, 128, 7, 7, 1);
		push_pixel(11, 128, 128, 8, 8, 1);
		push_pixel(35, 128, 128, 9, 9, 1);
		push_pixel(36, 128, 128, 10, 10, 1);
		push_pixel(77, 128, 128, 11, 11, 1);
		push_pixel(78, 128, 128, 12, 12, 1);
		push_pixel(105, 128, 128, 13, 13, 1);
		push_pixel(106, 128, 128, 14, 14, 1);
		push_pixel(135, 128, 128, 15, 15, 1);
		push_pixel(136, 128, 128, 16, 16, 1);
		push_pixel(160, 128, 128, 17, 17, 1);
		push_pixel(161, 128, 128, 18, 18, 1);
		push_pixel(180, 128, 128, 19, 19, 1);
		// tie between green and red goes to red
		push_pixel(36, 100, 100, 1024, 1024, 0);
		push_pixel(0, 100, 100, 1365, 682, 1);
		// majority green
		push_pixel(50, 100, 100, 100, 200, 0);
		push_pixel(120, 100, 100, 300, 400, 0);
		push_pixel(50, 100, 100, 500, 600, 1);
		queue_frames(PIXELS_PER_SETUP);

		apply_setup(4095, 4095, -2048, -2048, 8191, 8191);
		queue_frames(PIXELS_PER_SETUP);
		apply_setup(0, 2048, 0, 0, 2048, 2048);
		queue_frames(PIXELS_PER_SETUP);
		apply_setup(1, 1, 0, 0, 1, 1);
		queue_frames(PIXELS_PER_SETUP);
		apply_setup(2048, 2048, 2047, 2047, 0, 0);
		queue_frames(PIXELS_PER_SETUP);
		apply_setup(2048, 2048, 2047, 2047, 4096, 4096);
		queue_frames(PIXELS_PER_SETUP);
		apply_setup(64, 48, 100, 10, 50, 20);
		queue_frames(PIXELS_PER_SETUP);
		apply_setup(640, 480, -5, -3, 10, 8);
		queue_frames(PIXELS_PER_SETUP);

		repeat (6) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: w = $urandom_range(1, 300);
				5, 6, 7: w = $urandom_range(0, 4095);
				default: w = 2048;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: h = $urandom_range(1, 300);
				5, 6, 7: h = $urandom_range(0, 4095);
				default: h = 2048;
			endcase
			left = ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, w + 20)) - 10
				: int'($urandom_range(0, 4095)) - 2048;
			top = ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, h + 20)) - 10
				: int'($urandom_range(0, 4095)) - 2048;
			if (left > 2047) left = 2047;
			if (top > 2047) top = 2047;
			cols = ($urandom_range(0, 4) < 3) ? $urandom_range(0, w) : $urandom_range(0, 8191);
			rows = ($urandom_range(0, 4) < 3) ? $urandom_range(0, h) : $urandom_range(0, 8191);
			apply_setup(w, h, left, top, cols, rows);
			queue_frames(PIXELS_PER_SETUP);
		end

		wait_idle();
		$display("covered %0d pixel transactions, %0d frame results, %0d register settings",
			pixels_seen, frames_seen, setups_run);
		$display("%0d mismatches, %0d results still pending", mismatches, color_expect.size());
		if (mismatches == 0 && color_expect.size() == 0) begin
			$display("roi_dominant_color_classifier_tb: done, clean");
		end else begin
			$display("roi_dominant_color_classifier_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("timeout with %0d results pending", color_expect.size());
		$display("roi_dominant_color_classifier_tb: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
src/rdcc_pkg.sv
src/rdcc_classify.sv
src/roi_dominant_color_classifier.sv
tb/roi_dominant_color_classifier_tb.sv
